// File: hdl/sgi_pkg.sv
// shared constants, codes and controller/datapath interface types for the gain interpolator
package sgi_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int MAX_POINTS_DEF = 8;

  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int STATUS_W = 2;
  localparam int PTS_W    = 4;
  localparam int SLOT_W   = 3;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SPEED  = 1'b1;

  localparam logic [PTS_W-1:0]   POINTS_RESET = 4'd2;
  localparam logic [SPEED_W-1:0] CUTOFF_RESET = SPEED_W'(1 << (FRAC_BITS - 1));

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SEG = 2'd2;

  // product of two 17-bit differences, magnitude below 2^32
  localparam int PROD_W     = 34;
  localparam int MAG_W      = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = MAG_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic start;
    logic idx_inc;
    logic lo_load;
    logic hi_load;
    logic mul_go;
    logic prep_go;
    logic div_step;
    logic acc_go;
    logic sat_go;
    logic res_zero;
    logic res_seg;
    logic out_load;
  } sgi_cmd_t;

  typedef struct packed {
    logic below;
    logic found;
    logic last;
    logic dv_zero;
    logic out_free;
  } sgi_sts_t;

endpackage

// File: hdl/sgi_ctrl.sv
// sequencing state machine: table scan, multiply, divide, saturate, hand-off
module sgi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  input  sgi_pkg::sgi_sts_t sts,
  output sgi_pkg::sgi_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_SAT   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [sgi_pkg::DIV_CNT_W-1:0] DIV_LAST =
    sgi_pkg::DIV_CNT_W'(sgi_pkg::DIV_CYCLES - 1);

  logic [3:0]                    state_r, state_nxt;
  logic [sgi_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_cmd == sgi_pkg::CMD_EVAL) begin
          cmd.start = 1'b1;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (sts.below) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.lo_load = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.found || sts.last) begin
          cmd.hi_load = 1'b1;
          state_nxt   = S_MUL;
        end else begin
          cmd.lo_load = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        if (sts.dv_zero) begin
          cmd.res_seg = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.prep_go = 1'b1;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_go = 1'b1;
        state_nxt  = S_SAT;
      end
      S_SAT: begin
        cmd.sat_go = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

`ifndef SYNTH
  // result register only reloaded once the previous word has gone
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  // an accepted evaluate word always starts with the first table entry
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == sgi_pkg::CMD_EVAL) |=> state_r == S_FIRST)
    else $error("evaluate did not start the scan");

  // divider runs its full count before the accumulate step
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == DIV_LAST) |=> state_r == S_ACC)
    else $error("divider count overrun");

  // at most one writer of the segment and result registers per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.lo_load, cmd.hi_load, cmd.res_zero, cmd.res_seg, cmd.sat_go}))
    else $error("conflicting datapath loads");
`endif

endmodule

// File: hdl/sgi_dpath.sv
// datapath: breakpoint memory, config registers, multiplier, radix-4 divider, saturation
module sgi_dpath #(
  parameter int MAX_POINTS = sgi_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sgi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_fire,
  input  logic                                in_cmd,
  input  logic [sgi_pkg::SLOT_W-1:0]          in_point_index,
  input  logic [sgi_pkg::SPEED_W-1:0]         in_point_speed,
  input  logic signed [sgi_pkg::GAIN_W-1:0]   in_point_gain,
  input  logic [sgi_pkg::SPEED_W-1:0]         in_speed,
  input  sgi_pkg::sgi_cmd_t                   cmd,
  output sgi_pkg::sgi_sts_t                   sts,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic signed [sgi_pkg::GAIN_W-1:0]   out_gain,
  output logic [sgi_pkg::STATUS_W-1:0]        out_status
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int SW     = sgi_pkg::SPEED_W;
  localparam int GW     = sgi_pkg::GAIN_W;
  localparam int PW     = sgi_pkg::PROD_W;
  localparam int MW     = sgi_pkg::MAG_W;

  // configuration
  logic [sgi_pkg::PTS_W-1:0] points_r;
  logic [SW-1:0]             cutoff_r;

  // breakpoint memory, one read port with registered data
  logic [SW-1:0]        mem_speed [MAX_POINTS];
  logic signed [GW-1:0] mem_gain  [MAX_POINTS];
  logic [IDX_W-1:0]     rd_idx_r, rd_next;
  logic [SW-1:0]        rd_speed_r;
  logic signed [GW-1:0] rd_gain_r;
  logic [IDX_W-1:0]     wr_addr;
  logic                 load_we;
  logic [IDX_W-1:0]     last_idx;

  // segment and arithmetic registers
  logic [SW-1:0]        s_r, lo_speed_r, hi_speed_r;
  logic signed [GW-1:0] lo_gain_r, hi_gain_r;
  logic signed [SW:0]   df_w, ds_w, dv_w;
  logic signed [PW-1:0] prod_r, prod_neg_w;
  logic signed [SW:0]   dv_r, dv_neg_w;
  logic [MW-1:0]        q_r, q_w;
  logic [SW-1:0]        rem_r, rem_w, den_r;
  logic [SW:0]          trial_w;
  logic                 neg_r;
  logic signed [PW-1:0] qs_w, acc_r;

  // result and output registers
  logic signed [GW-1:0]           res_gain_r, out_gain_r;
  logic [sgi_pkg::STATUS_W-1:0]   res_status_r, out_status_r;
  logic                           out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= sgi_pkg::POINTS_RESET;
      cutoff_r <= sgi_pkg::CUTOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgi_pkg::REG_POINTS_IN_USE: points_r <= cfg_data[sgi_pkg::PTS_W-1:0];
        sgi_pkg::REG_CUTOFF_SPEED:  cutoff_r <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // slots beyond the table are dropped
  assign wr_addr = IDX_W'(in_point_index);
  assign load_we = in_fire && (in_cmd == sgi_pkg::CMD_LOAD) &&
                   (int'(in_point_index) < MAX_POINTS);

  always_comb begin
    if (cmd.start) begin
      rd_next = '0;
    end else if (cmd.idx_inc) begin
      rd_next = IDX_W'(rd_idx_r + 1'b1);
    end else begin
      rd_next = rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_speed[wr_addr] <= in_point_speed;
      mem_gain[wr_addr]  <= in_point_gain;
    end
    rd_speed_r <= mem_speed[rd_next];
    rd_gain_r  <= mem_gain[rd_next];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_next;
    end
  end

  // index of the last point in use, clamped to the table
  always_comb begin
    if (points_r < 4'd2) begin
      last_idx = IDX_W'(1);
    end else if (int'(points_r) > MAX_POINTS) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(points_r - 4'd1);
    end
  end

  assign sts.below    = (s_r < cutoff_r) || (s_r < rd_speed_r);
  assign sts.found    = (s_r >= lo_speed_r) && (s_r < rd_speed_r);
  assign sts.last     = (rd_idx_r == last_idx);
  assign sts.dv_zero  = (hi_speed_r == lo_speed_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign df_w = $signed({hi_gain_r[GW-1], hi_gain_r}) - $signed({lo_gain_r[GW-1], lo_gain_r});
  assign ds_w = $signed({1'b0, s_r}) - $signed({1'b0, lo_speed_r});
  assign dv_w = $signed({1'b0, hi_speed_r}) - $signed({1'b0, lo_speed_r});

  assign prod_neg_w = -prod_r;
  assign dv_neg_w   = -dv_r;

  // two restoring steps per cycle
  always_comb begin
    rem_w   = rem_r;
    q_w     = q_r;
    trial_w = '0;
    for (int j = 0; j < sgi_pkg::DIV_STEPS; j++) begin
      trial_w = {rem_w, q_w[MW-1]};
      q_w     = {q_w[MW-2:0], 1'b0};
      if (trial_w >= {1'b0, den_r}) begin
        trial_w = trial_w - {1'b0, den_r};
        q_w[0]  = 1'b1;
      end
      rem_w = trial_w[SW-1:0];
    end
  end

  assign qs_w = neg_r ? -$signed({{(PW-MW){1'b0}}, q_r}) : $signed({{(PW-MW){1'b0}}, q_r});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s_r <= in_speed;
    end
    if (cmd.lo_load) begin
      lo_speed_r <= rd_speed_r;
      lo_gain_r  <= rd_gain_r;
    end
    if (cmd.hi_load) begin
      hi_speed_r <= rd_speed_r;
      hi_gain_r  <= rd_gain_r;
    end
    if (cmd.mul_go) begin
      prod_r <= PW'(df_w) * PW'(ds_w);
      dv_r   <= dv_w;
    end
    if (cmd.prep_go) begin
      q_r   <= prod_r[PW-1] ? prod_neg_w[MW-1:0] : prod_r[MW-1:0];
      den_r <= dv_r[SW] ? dv_neg_w[SW-1:0] : dv_r[SW-1:0];
      neg_r <= prod_r[PW-1] ^ dv_r[SW];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_w;
      rem_r <= rem_w;
    end
    if (cmd.acc_go) begin
      acc_r <= $signed({{(PW-GW){lo_gain_r[GW-1]}}, lo_gain_r}) + qs_w;
    end
    if (cmd.res_zero) begin
      res_gain_r   <= '0;
      res_status_r <= sgi_pkg::ST_OK;
    end else if (cmd.res_seg) begin
      res_gain_r   <= lo_gain_r;
      res_status_r <= sgi_pkg::ST_ZERO_SEG;
    end else if (cmd.sat_go) begin
      if (acc_r > 34'sd32767) begin
        res_gain_r   <= 16'sh7fff;
        res_status_r <= sgi_pkg::ST_SAT;
      end else if (acc_r < -34'sd32768) begin
        res_gain_r   <= 16'sh8000;
        res_status_r <= sgi_pkg::ST_SAT;
      end else begin
        res_gain_r   <= acc_r[GW-1:0];
        res_status_r <= sgi_pkg::ST_OK;
      end
    end
    if (cmd.out_load) begin
      out_gain_r   <= res_gain_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_gain   = out_gain_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/speed_gain_interpolator_unit.sv
// speed to gain piecewise-linear interpolator, top level
// timing: a load word is written in its accept cycle; an evaluate word gives its result
//   from S_DONE, via the table scan and arithmetic states unless below cutoff or first point
// throughput: one word in flight; loads every cycle while idle, an evaluate holds off new words
//   until handed off, after the serial table scan, the radix-4 divider and any out_tready stall
// reset: rst_n synchronous, active low; clears control, output valid and config registers,
//   breakpoint table is not cleared
module speed_gain_interpolator_unit #(
  parameter int MAX_POINTS = sgi_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd [0], point_index [3:1], point_speed [19:4], point_gain [35:20], speed [51:36]
  input  logic [sgi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // gain [15:0], status [17:16]
  output logic [sgi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // register writes: 0 points_in_use, 1 cutoff_speed
  input  logic                               cfg_we,
  input  logic [sgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sgi_pkg::sgi_cmd_t cmd;
  sgi_pkg::sgi_sts_t sts;

  // unpacked input fields
  logic                                     in_cmd;
  logic [sgi_pkg::SLOT_W-1:0]               in_point_index;
  logic [sgi_pkg::SPEED_W-1:0]              in_point_speed;
  logic signed [sgi_pkg::GAIN_W-1:0]        in_point_gain;
  logic [sgi_pkg::SPEED_W-1:0]              in_speed;
  logic                                     in_fire;
  logic signed [sgi_pkg::GAIN_W-1:0]        out_gain;
  logic [sgi_pkg::STATUS_W-1:0]             out_status;

  assign in_cmd         = in_tdata[0];
  assign in_point_index = in_tdata[3:1];
  assign in_point_speed = in_tdata[19:4];
  assign in_point_gain  = in_tdata[35:20];
  assign in_speed       = in_tdata[51:36];
  assign in_fire        = in_tvalid && in_tready;

  // the controller owns the handshake, the datapath owns all values
  sgi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_cmd),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgi_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_fire        (in_fire),
    .in_cmd         (in_cmd),
    .in_point_index (in_point_index),
    .in_point_speed (in_point_speed),
    .in_point_gain  (in_point_gain),
    .in_speed       (in_speed),
    .cmd            (cmd),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_gain       (out_gain),
    .out_status     (out_status)
  );

  // pad to whole bytes
  assign out_tdata = {6'b0, out_status, out_gain};

endmodule
